@@ rtl/sgs_pkg.sv @@
`timescale 1ns / 1ps

package sgs_pkg;

    localparam int GRID_SIDE  = 8;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int COORD_W    = $clog2(GRID_SIDE);
    localparam int IDX_W      = $clog2(CELL_COUNT);

    localparam int FIELD_W  = 3;
    localparam int COLOR_W  = 2;
    localparam int HEIGHT_W = 8;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = '1;
    localparam logic [HEIGHT_W-1:0] TOPPLE_LIMIT = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] TOPPLE_LOSS  = HEIGHT_W'(4);

    // neighbor order within a topple
    localparam int NB_UP    = 0;
    localparam int NB_DOWN  = 1;
    localparam int NB_LEFT  = 2;
    localparam int NB_RIGHT = 3;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_DROP_RD  = 10'b00_0000_0010,
        ST_DROP_WR  = 10'b00_0000_0100,
        ST_CELL_RD  = 10'b00_0000_1000,
        ST_CELL_CHK = 10'b00_0001_0000,
        ST_NB_RD    = 10'b00_0010_0000,
        ST_NB_WR    = 10'b00_0100_0000,
        ST_OUT_RD   = 10'b00_1000_0000,
        ST_OUT_LD   = 10'b01_0000_0000,
        ST_OUT_WAIT = 10'b10_0000_0000
    } state_t;

    function automatic logic [IDX_W-1:0] cell_idx(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        int sum;
        sum = int'(y) * GRID_SIDE + int'(x);
        return IDX_W'(sum);
    endfunction

    function automatic logic [HEIGHT_W-1:0] sat_inc(input logic [HEIGHT_W-1:0] h);
        return (h == HEIGHT_MAX) ? h : h + HEIGHT_W'(1);
    endfunction

endpackage

@@ rtl/sandpile_grid_sweep.sv @@
`timescale 1ns / 1ps

// An in-range drop reads then writes its cell; the sweep reads and checks each cell, reads
// then writes each neighbor that gets a grain, opens the frame, then loads each output
// word and holds it under cell_stall. No new drop is taken before the frame ends. A height
// memory port pair serves every step and one increment/subtract unit does every write.
// Reset: rst_n is asynchronous, active low; all heights read as zero after reset
// through per-cell valid bits, no clearing pass.
module sandpile_grid_sweep (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         drop_valid,
    output logic                         drop_stall,
    input  logic [sgs_pkg::FIELD_W-1:0]  drop_x,
    input  logic [sgs_pkg::FIELD_W-1:0]  drop_y,
    output logic                         cell_valid,
    input  logic                         cell_stall,
    output logic [sgs_pkg::FIELD_W-1:0]  cell_x,
    output logic [sgs_pkg::FIELD_W-1:0]  cell_y,
    output logic [sgs_pkg::COLOR_W-1:0]  color_index,
    output logic                         last
);
    import sgs_pkg::*;

    state_t state_reg, state_next;

    logic [COORD_W-1:0]  cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]  cur_y_reg, cur_y_next;
    logic [IDX_W-1:0]    wr_addr_reg, wr_addr_next;
    logic [3:0]          pend_reg, pend_next;

    logic [HEIGHT_W-1:0] heights_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] written_reg;
    logic [HEIGHT_W-1:0] rdata_reg;
    logic                rvalid_reg;

    logic                cell_valid_reg, cell_valid_next;
    logic [FIELD_W-1:0]  cell_x_reg, cell_y_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic                last_reg;

    logic [IDX_W-1:0]    cur_idx, next_idx, nb_addr, raddr;
    logic [COORD_W-1:0]  nx, ny;
    logic                last_col, last_cell;
    logic                up_ok, down_ok, left_ok, right_ok;
    logic [3:0]          pend_left;
    logic [HEIGHT_W-1:0] h, alu_out;
    logic                mem_we, drop_ok, load_out;

    assign h         = rvalid_reg ? rdata_reg : '0;
    assign cur_idx   = cell_idx(cur_x_reg, cur_y_reg);
    assign last_col  = (cur_x_reg == COORD_W'(GRID_SIDE - 1));
    assign last_cell = last_col && (cur_y_reg == COORD_W'(GRID_SIDE - 1));
    assign nx        = last_col ? '0 : cur_x_reg + COORD_W'(1);
    assign ny        = last_cell ? '0 : (last_col ? cur_y_reg + COORD_W'(1) : cur_y_reg);
    assign next_idx  = cell_idx(nx, ny);

    assign up_ok    = (cur_y_reg != '0);
    assign down_ok  = (cur_y_reg != COORD_W'(GRID_SIDE - 1));
    assign left_ok  = (cur_x_reg != '0);
    assign right_ok = !last_col;

    assign drop_ok = (int'(drop_x) < GRID_SIDE) && (int'(drop_y) < GRID_SIDE);

    // shared unit: saturating increment, or the topple loss
    assign alu_out = (state_reg == ST_CELL_CHK) ? h - TOPPLE_LOSS : sat_inc(h);

    always_comb
    begin
        pend_left = pend_reg;
        nb_addr   = cur_idx;
        priority if (pend_reg[NB_UP])
        begin
            nb_addr = cell_idx(cur_x_reg, cur_y_reg - COORD_W'(1));
            pend_left[NB_UP] = 1'b0;
        end
        else if (pend_reg[NB_DOWN])
        begin
            nb_addr = cell_idx(cur_x_reg, cur_y_reg + COORD_W'(1));
            pend_left[NB_DOWN] = 1'b0;
        end
        else if (pend_reg[NB_LEFT])
        begin
            nb_addr = cell_idx(cur_x_reg - COORD_W'(1), cur_y_reg);
            pend_left[NB_LEFT] = 1'b0;
        end
        else if (pend_reg[NB_RIGHT])
        begin
            nb_addr = cell_idx(cur_x_reg + COORD_W'(1), cur_y_reg);
            pend_left[NB_RIGHT] = 1'b0;
        end
        else
        begin
            nb_addr = cur_idx;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        wr_addr_next    = wr_addr_reg;
        pend_next       = pend_reg;
        cell_valid_next = cell_valid_reg;
        raddr           = cur_idx;
        mem_we          = 1'b0;
        load_out        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (drop_valid)
                begin
                    cur_x_next   = '0;
                    cur_y_next   = '0;
                    wr_addr_next = cell_idx(COORD_W'(drop_x), COORD_W'(drop_y));
                    state_next   = drop_ok ? ST_DROP_RD : ST_CELL_RD;
                end
            end
            ST_DROP_RD:
            begin
                raddr      = wr_addr_reg;
                state_next = ST_DROP_WR;
            end
            ST_DROP_WR:
            begin
                mem_we     = 1'b1;
                state_next = ST_CELL_RD;
            end
            ST_CELL_RD:
            begin
                wr_addr_next = cur_idx;
                state_next   = ST_CELL_CHK;
            end
            ST_CELL_CHK:
            begin
                if (h > TOPPLE_LIMIT)
                begin
                    mem_we     = 1'b1;
                    pend_next  = {right_ok, left_ok, down_ok, up_ok};
                    state_next = ST_NB_RD;
                end
                else
                begin
                    cur_x_next = nx;
                    cur_y_next = ny;
                    state_next = last_cell ? ST_OUT_RD : ST_CELL_RD;
                end
            end
            ST_NB_RD:
            begin
                raddr        = nb_addr;
                wr_addr_next = nb_addr;
                pend_next    = pend_left;
                state_next   = ST_NB_WR;
            end
            ST_NB_WR:
            begin
                mem_we = 1'b1;
                if (pend_reg != '0)
                begin
                    state_next = ST_NB_RD;
                end
                else
                begin
                    cur_x_next = nx;
                    cur_y_next = ny;
                    state_next = last_cell ? ST_OUT_RD : ST_CELL_RD;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                load_out        = 1'b1;
                cell_valid_next = 1'b1;
                state_next      = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                raddr = next_idx;
                if (!cell_stall)
                begin
                    cell_valid_next = 1'b0;
                    cur_x_next      = nx;
                    cur_y_next      = ny;
                    state_next      = last_reg ? ST_IDLE : ST_OUT_LD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            wr_addr_reg    <= '0;
            pend_reg       <= '0;
            cell_valid_reg <= 1'b0;
            written_reg    <= '0;
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            wr_addr_reg    <= wr_addr_next;
            pend_reg       <= pend_next;
            cell_valid_reg <= cell_valid_next;
            rvalid_reg     <= written_reg[raddr];
            if (mem_we)
            begin
                written_reg[wr_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heights_mem[wr_addr_reg] <= alu_out;
        end
        rdata_reg <= heights_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            cell_x_reg <= FIELD_W'(cur_x_reg);
            cell_y_reg <= FIELD_W'(cur_y_reg);
            color_reg  <= h[COLOR_W-1:0];
            last_reg   <= last_cell;
        end
    end

    assign drop_stall  = (state_reg != ST_IDLE);
    assign cell_valid  = cell_valid_reg;
    assign cell_x      = cell_x_reg;
    assign cell_y      = cell_y_reg;
    assign color_index = color_reg;
    assign last        = last_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_drop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (drop_valid && !drop_stall) |=> drop_stall)
        else $error("second word taken while a tick is in progress");

    a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid |-> (state_reg == ST_OUT_WAIT))
        else $error("output word valid outside the output phase");

    a_nb_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NB_RD) |-> (pend_reg != '0))
        else $error("neighbor read with nothing pending");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall && last) |=> !drop_stall)
        else $error("block not ready after the final word of a frame");

    a_no_write_out: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !cell_valid)
        else $error("height memory written during output");

endmodule

@@ tb/tb_sandpile_grid_sweep.sv @@
`timescale 1ns / 1ps

module tb_sandpile_grid_sweep;
    import sgs_pkg::*;

    localparam int NO_PIN       = -1;
    localparam int SCRIPT_ROWS  = 20;
    localparam int RANDOM_DROPS = 460;
    localparam int HOLD_AFTER   = 3000;
    localparam int HOLD_CYCLES  = 4000;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } cell_word_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               drop_valid  = 1'b0;
    logic               drop_stall;
    logic [FIELD_W-1:0] drop_x      = '0;
    logic [FIELD_W-1:0] drop_y      = '0;
    logic               cell_valid;
    logic               cell_stall  = 1'b0;
    logic [FIELD_W-1:0] cell_x;
    logic [FIELD_W-1:0] cell_y;
    logic [COLOR_W-1:0] color_index;
    logic               last;

    logic [HEIGHT_W-1:0] pile [CELL_COUNT];
    cell_word_t          frame_q [$];
    int                  pinned_color = NO_PIN;
    int                  error_count  = 0;
    int                  words_seen   = 0;

    // x, y, color of the dropped cell after the tick (NO_PIN: predictor only)
    int script [SCRIPT_ROWS][3] = '{
        '{0, 0, 1}, '{7, 7, 1}, '{7, 0, 1}, '{0, 7, 1},
        '{0, 0, 2}, '{0, 0, 3}, '{0, 0, 0},
        '{3, 4, 1}, '{3, 4, 2}, '{3, 4, 3}, '{3, 4, 0},
        '{7, 7, 2}, '{7, 7, 3}, '{7, 7, 0},
        '{5, 2, NO_PIN}, '{2, 6, NO_PIN}, '{1, 0, 2},
        '{6, 3, NO_PIN}, '{4, 1, NO_PIN}, '{7, 3, NO_PIN}
    };

    sandpile_grid_sweep i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .drop_valid  (drop_valid),
        .drop_stall  (drop_stall),
        .drop_x      (drop_x),
        .drop_y      (drop_y),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .color_index (color_index),
        .last        (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void add_grain(input int x, input int y);
        int idx;
        idx = y * GRID_SIDE + x;
        if (pile[idx] != HEIGHT_MAX)
            pile[idx] = pile[idx] + 1'b1;
    endfunction

    // drop, one raster sweep, then queue the whole frame
    function automatic void run_tick(input int dx, input int dy, input int pin);
        int         idx;
        cell_word_t w;
        if (dx < GRID_SIDE && dy < GRID_SIDE)
            add_grain(dx, dy);
        for (int y = 0; y < GRID_SIDE; y++)
        begin
            for (int x = 0; x < GRID_SIDE; x++)
            begin
                idx = y * GRID_SIDE + x;
                if (pile[idx] > TOPPLE_LIMIT)
                begin
                    pile[idx] = pile[idx] - TOPPLE_LOSS;
                    if (y > 0)
                        add_grain(x, y - 1);
                    if (y + 1 < GRID_SIDE)
                        add_grain(x, y + 1);
                    if (x > 0)
                        add_grain(x - 1, y);
                    if (x + 1 < GRID_SIDE)
                        add_grain(x + 1, y);
                end
            end
        end
        for (int y = 0; y < GRID_SIDE; y++)
        begin
            for (int x = 0; x < GRID_SIDE; x++)
            begin
                idx     = y * GRID_SIDE + x;
                w.x     = FIELD_W'(x);
                w.y     = FIELD_W'(y);
                w.color = pile[idx][COLOR_W-1:0];
                if (pin != NO_PIN && x == dx && y == dy)
                    w.color = COLOR_W'(pin);
                w.last  = (idx == CELL_COUNT - 1);
                frame_q.push_back(w);
            end
        end
    endfunction

    initial
    begin
        for (int i = 0; i < CELL_COUNT; i++)
            pile[i] = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n && drop_valid && !drop_stall)
            run_tick(int'(drop_x), int'(drop_y), pinned_color);
    end

    always @(posedge clk)
    begin
        cell_word_t want;
        cell_word_t got;
        if (rst_n && cell_valid && !cell_stall)
        begin
            words_seen++;
            got = '{cell_x, cell_y, color_index, last};
            if (frame_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected word x=%0d y=%0d color=%0d last=%0d",
                             $time, got.x, got.y, got.color, got.last);
            end
            else
            begin
                want = frame_q.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"%0t: mismatch exp x=%0d y=%0d color=%0d last=%0d,",
                                  " got x=%0d y=%0d color=%0d last=%0d"},
                                 $time, want.x, want.y, want.color, want.last,
                                 got.x, got.y, got.color, got.last);
                end
            end
        end
    end

    // offer one drop at the current falling edge, return at the falling edge after acceptance
    task automatic send_drop(input int x, input int y, input int pin);
        drop_x       = FIELD_W'(x);
        drop_y       = FIELD_W'(y);
        pinned_color = pin;
        drop_valid   = 1'b1;
        do
            @(posedge clk);
        while (drop_stall);
        @(negedge clk);
    endtask

    initial
    begin
        bit held;
        int run_len;
        int level;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && words_seen >= HOLD_AFTER)
            begin
                cell_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                cell_stall = 1'b0;
                held = 1'b1;
            end
            else
            begin
                run_len = $urandom_range(5, 60);
                case ($urandom_range(4))
                    0, 1: level = 0;
                    2: level = 30;
                    3: level = 60;
                    default: level = 90;
                endcase
                repeat (run_len)
                begin
                    cell_stall = ($urandom_range(99) < level);
                    @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        int sent;
        int burst;
        int gap;
        int hot_x;
        int hot_y;
        int x;
        int y;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < SCRIPT_ROWS; r++)
            send_drop(script[r][0], script[r][1], script[r][2]);
        drop_valid = 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);

        sent  = 0;
        hot_x = $urandom_range(7);
        hot_y = $urandom_range(7);
        while (sent < RANDOM_DROPS)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < RANDOM_DROPS; k++)
            begin
                if (sent % 16 == 0)
                begin
                    hot_x = $urandom_range(7);
                    hot_y = $urandom_range(7);
                end
                // mostly clustered drops to build up cascades
                if ($urandom_range(99) < 60)
                begin
                    x = (hot_x + $urandom_range(1)) % GRID_SIDE;
                    y = (hot_y + $urandom_range(1)) % GRID_SIDE;
                end
                else
                begin
                    x = $urandom_range(GRID_SIDE - 1);
                    y = $urandom_range(GRID_SIDE - 1);
                end
                send_drop(x, y, NO_PIN);
                sent++;
            end
            drop_valid = 1'b0;
            if ($urandom_range(7) == 0)
                gap = $urandom_range(40, 200);
            else
                gap = $urandom_range(0, 12);
            repeat (gap) @(negedge clk);
        end
        drop_valid = 1'b0;

        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("tb_sandpile_grid_sweep: clean");
        else
            $display("tb_sandpile_grid_sweep: errors");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("tb_sandpile_grid_sweep: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/sgs_pkg.sv
rtl/sandpile_grid_sweep.sv
tb/tb_sandpile_grid_sweep.sv
